[hdl/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define SCOS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scos assertion failed");

// Next-cycle implication, disabled while rst is high.
`define SCOS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scos assertion failed");

`endif

[hdl/scos_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scos_pkg
// Widths, codes and shared types of the sphere contact statistics block.
// ----------------------------------------------------------------------------
package scos_pkg;

   localparam int POS_W      = 32;
   localparam int RAD_W      = 31;
   localparam int DIFF_W     = 33;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int ROOT_W     = 35;
   localparam int RADICAND_W = 2 * ROOT_W;
   localparam int ENTRY_W    = 3 * POS_W + RAD_W;
   localparam int TOL_W      = 16;
   localparam int DIST_SH    = 16;
   localparam int MEAN_W     = 16;
   localparam int COORD_W    = 14;
   localparam int CONTACT_W  = 12;
   localparam int SPHERE_W   = 7;
   localparam int MEAN_FRAC  = 14;
   localparam int COORD_SH   = 9;   // contacts * 256 = pairs * 512

   localparam logic [TOL_W-1:0]     TOL_RESET     = 16'd655;
   localparam logic [MEAN_W-1:0]    MEAN_POS_MAX  = 16'h7FFF;
   localparam logic [MEAN_W-1:0]    MEAN_NEG_MAX  = 16'h8000;
   localparam logic [COORD_W-1:0]   COORD_MAX     = 14'h3FFF;
   localparam logic [CONTACT_W-1:0] CONTACT_MAX   = 12'hFFF;
   localparam logic [SPHERE_W-1:0]  SPHERE_MAX    = 7'h7F;

   typedef enum logic [4:0] {
      ST_IDLE, ST_START, ST_RD_I, ST_CAP_A, ST_RD_J, ST_DIFF,
      ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_END, ST_SQRT, ST_SQRT_WAIT,
      ST_TMUL, ST_TEST, ST_COEF_WAIT, ST_ACC, ST_NEXT,
      ST_MEAN, ST_MEAN_WAIT, ST_COORD, ST_COORD_WAIT, ST_EMIT
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_START, OP_RD_I, OP_CAP_A, OP_RD_J, OP_DIFF,
      OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_SQ_END, OP_SQRT, OP_TMUL, OP_TEST,
      OP_ACC, OP_NEXT, OP_DIV_MEAN, OP_DIV_COORD, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic n_small;
      logic i_last;
      logic j_last;
      logic touch;
      logic s_zero;
      logic pairs_zero;
      logic sqrt_busy;
      logic div_busy;
      logic out_busy;
   } dp_status_type;

endpackage

[hdl/scos_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scos_req_if / scos_rsp_if
// Valid/ready channels for sphere items and statistics items.
// ----------------------------------------------------------------------------
interface scos_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [scos_pkg::POS_W-1:0]   pos_x;
   logic signed [scos_pkg::POS_W-1:0]   pos_y;
   logic signed [scos_pkg::POS_W-1:0]   pos_z;
   logic        [scos_pkg::RAD_W-1:0]   sphere_radius;
   logic                                last_sphere;

   modport source (output valid, pos_x, pos_y, pos_z, sphere_radius, last_sphere,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, sphere_radius, last_sphere,
                   output ready);
endinterface

interface scos_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [scos_pkg::MEAN_W-1:0]    mean_overlap;
   logic        [scos_pkg::COORD_W-1:0]   coord_num;
   logic        [scos_pkg::CONTACT_W-1:0] contact_count;
   logic        [scos_pkg::SPHERE_W-1:0]  sphere_count;
   logic                                  overflow;

   modport source (output valid, mean_overlap, coord_num, contact_count,
                   sphere_count, overflow, input ready);
   modport sink   (input valid, mean_overlap, coord_num, contact_count,
                   sphere_count, overflow, output ready);
endinterface

[hdl/scos_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scos_sqrt
// Bit-serial floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module scos_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [scos_pkg::RADICAND_W-1:0] radicand,
   output logic                            busy,
   output logic [scos_pkg::ROOT_W-1:0]     root
);
   import scos_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W + 1);
   localparam int REM_W = ROOT_W + 3;

   logic [RADICAND_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in, rem_t, trial;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   always_comb begin
      rem_t   = {rem_ff[REM_W-3:0], rad_ff[RADICAND_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RADICAND_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

[hdl/scos_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scos_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scos_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [DEN_W:0]   part;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   always_comb begin
      part    = {rem_ff, num_ff[NUM_W-1]};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (part >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(part - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = part[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

[hdl/scos_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scos_dp
// Datapath: sphere store, pair indexes, shared multiplier, root and divider
// units, accumulators and the result register.
// ----------------------------------------------------------------------------
module scos_dp #(
   parameter int MAX_SPHERES     = 64,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  scos_pkg::dp_op_type                   op,
   output scos_pkg::dp_status_type               status,
   input  logic        [scos_pkg::POS_W-1:0]     pos_x,
   input  logic        [scos_pkg::POS_W-1:0]     pos_y,
   input  logic        [scos_pkg::POS_W-1:0]     pos_z,
   input  logic        [scos_pkg::RAD_W-1:0]     sphere_radius,
   input  logic                                  csr_wr_en,
   input  logic        [scos_pkg::TOL_W-1:0]     csr_wr_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [scos_pkg::MEAN_W-1:0]    mean_overlap,
   output logic        [scos_pkg::COORD_W-1:0]   coord_num,
   output logic        [scos_pkg::CONTACT_W-1:0] contact_count,
   output logic        [scos_pkg::SPHERE_W-1:0]  sphere_count,
   output logic                                  overflow
);
   import scos_pkg::*;

   localparam int F       = COORD_FRAC_BITS;
   localparam int AW      = $clog2(MAX_SPHERES);
   localparam int CW      = $clog2(MAX_SPHERES + 1);
   localparam int PAIR_W  = $clog2(MAX_SPHERES * (MAX_SPHERES - 1) / 2 + 1);
   localparam int SUM_W   = PAIR_W + F + 2;
   localparam int MNUM_W  = PAIR_W + F + 16;
   localparam int CNUM_W  = POS_W + F;
   localparam int NUM_W   = (MNUM_W > CNUM_W) ? MNUM_W : CNUM_W;
   localparam int DEN_W   = (PAIR_W + F > DIFF_W) ? PAIR_W + F : DIFF_W;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
      logic [DIFF_W-1:0] d;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      abs_diff = d[DIFF_W-1] ? DIFF_W'(~d + 1'b1) : d;
   endfunction

   logic [ENTRY_W-1:0] mem [MAX_SPHERES];

   logic [CW-1:0]       count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [TOL_W-1:0]    tol_ff;
   logic [AW-1:0]       i_ff, i_in, j_ff, j_in;
   logic [ENTRY_W-1:0]  a_ff, a_in, rdata_ff;
   logic [DIFF_W-1:0]   dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in, s_ff, s_in;
   logic [SQ_W-1:0]     prod_ff, prod_in, acc_ff, acc_in;
   logic [PAIR_W-1:0]   pairs_ff, pairs_in;
   logic [SUM_W-1:0]    sum_ff, sum_in, sum_mag, coef;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic                rv_ff, rv_in;
   logic [MEAN_W-1:0]   om_ff, om_in;
   logic [COORD_W-1:0]  oc_ff, oc_in;
   logic [CONTACT_W-1:0] ok_ff, ok_in;
   logic [SPHERE_W-1:0] os_ff, os_in;
   logic                oo_ff, oo_in;

   logic [DIFF_W-1:0]   mul_a, mul_b;
   logic [AW-1:0]       rd_addr;
   logic                store_full, sum_neg, dist_le, touch, s_zero;
   logic [ROOT_W-1:0]   gap, mag_full;
   logic                sqrt_busy, div_busy, div_start;
   logic [NUM_W-1:0]    div_num, quo;
   logic [DEN_W-1:0]    div_den;
   logic [PAIR_W:0]     contacts;

   scos_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (op == OP_SQRT),
      .radicand (RADICAND_W'(acc_ff)),
      .busy     (sqrt_busy),
      .root     (gap)
   );

   scos_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (quo)
   );

   assign store_full = (count_ff == CW'(MAX_SPHERES));
   assign s_zero     = (s_ff == '0);
   assign touch      = SQ_W'({gap, DIST_SH'(0)}) <= prod_ff;
   assign dist_le    = gap <= ROOT_W'(s_ff);
   assign mag_full   = dist_le ? ROOT_W'(s_ff) - gap : gap - ROOT_W'(s_ff);
   assign sum_neg    = sum_ff[SUM_W-1];
   assign sum_mag    = sum_neg ? SUM_W'(~sum_ff + 1'b1) : sum_ff;
   assign coef       = SUM_W'(quo[F:0]);
   assign contacts   = {pairs_ff, 1'b0};
   assign rd_addr    = (op == OP_RD_I) ? i_ff : j_ff;

   always_comb begin
      status.n_small    = count_ff < CW'(2);
      status.i_last     = (CW'(i_ff) + CW'(2)) == count_ff;
      status.j_last     = (CW'(j_ff) + CW'(1)) == count_ff;
      status.touch      = touch;
      status.s_zero     = s_zero;
      status.pairs_zero = (pairs_ff == '0);
      status.sqrt_busy  = sqrt_busy;
      status.div_busy   = div_busy;
      status.out_busy   = rv_ff;
   end

   // Shared multiplier operands and divider operands
   always_comb begin
      mul_a     = dx_ff;
      mul_b     = dx_ff;
      div_start = 1'b0;
      div_num   = NUM_W'({mag_full[POS_W-1:0], F'(0)});
      div_den   = DEN_W'(s_ff);
      case (op)
         OP_SQ_Y: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         OP_SQ_Z: begin
            mul_a = dz_ff;
            mul_b = dz_ff;
         end
         OP_TMUL: begin
            mul_a = s_ff;
            mul_b = DIFF_W'({1'b1, tol_ff});
         end
         OP_TEST: begin
            div_start = touch && !s_zero;
         end
         OP_DIV_MEAN: begin
            div_start = 1'b1;
            div_num   = (NUM_W'(sum_mag) << MEAN_FRAC) + (NUM_W'(pairs_ff) << (F - 1));
            div_den   = DEN_W'(pairs_ff) << F;
         end
         OP_DIV_COORD: begin
            div_start = 1'b1;
            div_num   = (NUM_W'(pairs_ff) << COORD_SH) + NUM_W'(count_ff >> 1);
            div_den   = DEN_W'(count_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      a_in     = a_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dz_in    = dz_ff;
      s_in     = s_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      pairs_in = pairs_ff;
      sum_in   = sum_ff;
      mean_in  = mean_ff;
      rv_in    = rv_ff && !rsp_ready;
      om_in    = om_ff;
      oc_in    = oc_ff;
      ok_in    = ok_ff;
      os_in    = os_ff;
      oo_in    = oo_ff;
      unique case (op)
         OP_LOAD: begin
            if (store_full) ovf_in = 1'b1;
            else count_in = count_ff + 1'b1;
         end
         OP_START: begin
            pairs_in = '0;
            sum_in   = '0;
            i_in     = '0;
         end
         OP_RD_I:  j_in = i_ff + 1'b1;
         OP_CAP_A: a_in = rdata_ff;
         OP_DIFF: begin
            dx_in = abs_diff(a_ff[ENTRY_W-1 -: POS_W], rdata_ff[ENTRY_W-1 -: POS_W]);
            dy_in = abs_diff(a_ff[ENTRY_W-1-POS_W -: POS_W],
                             rdata_ff[ENTRY_W-1-POS_W -: POS_W]);
            dz_in = abs_diff(a_ff[RAD_W +: POS_W], rdata_ff[RAD_W +: POS_W]);
            s_in  = DIFF_W'(a_ff[RAD_W-1:0]) + DIFF_W'(rdata_ff[RAD_W-1:0]);
         end
         OP_SQ_X: prod_in = mul_a * mul_b;
         OP_SQ_Y: begin
            acc_in  = prod_ff;
            prod_in = mul_a * mul_b;
         end
         OP_SQ_Z: begin
            acc_in  = acc_ff + prod_ff;
            prod_in = mul_a * mul_b;
         end
         OP_SQ_END: acc_in  = acc_ff + prod_ff;
         OP_TMUL:   prod_in = mul_a * mul_b;
         OP_TEST: begin
            if (touch) pairs_in = pairs_ff + 1'b1;
         end
         OP_ACC: sum_in = dist_le ? sum_ff + coef : sum_ff - coef;
         OP_NEXT: begin
            if (status.j_last) i_in = i_ff + 1'b1;
            else j_in = j_ff + 1'b1;
         end
         OP_DIV_COORD: begin
            // quotient still holds the mean at this point
            if (sum_neg) begin
               mean_in = (quo > NUM_W'(32768)) ? MEAN_NEG_MAX
                                                : (~quo[MEAN_W-1:0]) + 1'b1;
            end else begin
               mean_in = (quo > NUM_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX : quo[MEAN_W-1:0];
            end
         end
         OP_EMIT: begin
            rv_in = 1'b1;
            if (status.pairs_zero) begin
               om_in = '0;
               oc_in = '0;
            end else begin
               om_in = mean_ff;
               oc_in = (quo > NUM_W'(COORD_MAX)) ? COORD_MAX : quo[COORD_W-1:0];
            end
            ok_in    = (32'(contacts) > 32'(CONTACT_MAX)) ? CONTACT_MAX
                                                          : CONTACT_W'(contacts);
            os_in    = (32'(count_ff) > 32'(SPHERE_MAX)) ? SPHERE_MAX
                                                         : SPHERE_W'(count_ff);
            oo_in    = ovf_ff;
            count_in = '0;
            ovf_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Sphere store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (op == OP_LOAD && !store_full) begin
         mem[count_ff[AW-1:0]] <= {pos_x, pos_y, pos_z, sphere_radius};
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_RD_I || op == OP_RD_J) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         tol_ff   <= TOL_RESET;
         rv_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
         if (csr_wr_en) tol_ff <= csr_wr_data;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      a_ff     <= a_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      s_ff     <= s_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      pairs_ff <= pairs_in;
      sum_ff   <= sum_in;
      mean_ff  <= mean_in;
      om_ff    <= om_in;
      oc_ff    <= oc_in;
      ok_ff    <= ok_in;
      os_ff    <= os_in;
      oo_ff    <= oo_in;
   end

   assign rsp_valid     = rv_ff;
   assign mean_overlap  = om_ff;
   assign coord_num     = oc_ff;
   assign contact_count = ok_ff;
   assign sphere_count  = os_ff;
   assign overflow      = oo_ff;

endmodule

[hdl/scos_ctl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scos_ctl
// Sequencer for loading, the pair pass and the final averages.
// ----------------------------------------------------------------------------
module scos_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    in_last,
   input  scos_pkg::dp_status_type status,
   output scos_pkg::dp_op_type     op,
   output logic                    in_ready
);
   import scos_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op = OP_LOAD;
               if (in_last) state_in = ST_START;
            end
         end
         ST_START: begin
            op       = OP_START;
            state_in = status.n_small ? ST_MEAN : ST_RD_I;
         end
         ST_RD_I: begin
            op       = OP_RD_I;
            state_in = ST_CAP_A;
         end
         ST_CAP_A: begin
            op       = OP_CAP_A;
            state_in = ST_RD_J;
         end
         ST_RD_J: begin
            op       = OP_RD_J;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            op       = OP_DIFF;
            state_in = ST_SQ_X;
         end
         ST_SQ_X: begin
            op       = OP_SQ_X;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            op       = OP_SQ_Y;
            state_in = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            op       = OP_SQ_Z;
            state_in = ST_SQ_END;
         end
         ST_SQ_END: begin
            op       = OP_SQ_END;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            op       = OP_SQRT;
            state_in = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (!status.sqrt_busy) state_in = ST_TMUL;
         end
         ST_TMUL: begin
            op       = OP_TMUL;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            op       = OP_TEST;
            state_in = (status.touch && !status.s_zero) ? ST_COEF_WAIT : ST_NEXT;
         end
         ST_COEF_WAIT: begin
            if (!status.div_busy) state_in = ST_ACC;
         end
         ST_ACC: begin
            op       = OP_ACC;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            op = OP_NEXT;
            if (!status.j_last) state_in = ST_RD_J;
            else if (status.i_last) state_in = ST_MEAN;
            else state_in = ST_RD_I;
         end
         ST_MEAN: begin
            if (status.pairs_zero) begin
               state_in = ST_EMIT;
            end else begin
               op       = OP_DIV_MEAN;
               state_in = ST_MEAN_WAIT;
            end
         end
         ST_MEAN_WAIT: begin
            if (!status.div_busy) state_in = ST_COORD;
         end
         ST_COORD: begin
            op       = OP_DIV_COORD;
            state_in = ST_COORD_WAIT;
         end
         ST_COORD_WAIT: begin
            if (!status.div_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               op       = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[hdl/sphere_contact_overlap_stats.sv]
`timescale 1ns / 1ps
// Sequence: after the last item the pair pass runs every pair through the
//   serial root, a new first sphere adds a store read, a touching pair with
//   nonzero radii adds a coefficient division, and the averages come last.
// Throughput: one item per cycle while loading; later steps hold off input.
// Reset: synchronous, active high; clears the count, overflow and the result
//   valid and sets the tolerance to 655; the sphere store is not cleared.
// ----------------------------------------------------------------------------
// sphere_contact_overlap_stats
// Pairwise sphere contact detection with mean overlap and coordination number.
// ----------------------------------------------------------------------------
module sphere_contact_overlap_stats #(
   parameter int MAX_SPHERES     = 64,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   scos_req_if.sink                         req_chan,
   scos_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [scos_pkg::TOL_W-1:0]       csr_wr_data
);
   import scos_pkg::*;

   dp_op_type     op;
   dp_status_type status;
   logic          in_ready;

   // Controller: decide one datapath operation per cycle.
   scos_ctl u_ctl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_last  (req_chan.last_sphere),
      .status   (status),
      .op       (op),
      .in_ready (in_ready)
   );

   // Ready only while loading; the result register decouples the output side,
   // so a new aggregate may load while the previous item waits to be taken.
   assign req_chan.ready = in_ready;

   scos_dp #(
      .MAX_SPHERES     (MAX_SPHERES),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .status        (status),
      .pos_x         (req_chan.pos_x),
      .pos_y         (req_chan.pos_y),
      .pos_z         (req_chan.pos_z),
      .sphere_radius (req_chan.sphere_radius),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .mean_overlap  (rsp_chan.mean_overlap),
      .coord_num     (rsp_chan.coord_num),
      .contact_count (rsp_chan.contact_count),
      .sphere_count  (rsp_chan.sphere_count),
      .overflow      (rsp_chan.overflow)
   );

endmodule

[hdl/scos_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scos_checker
// Port-level checks on the statistics item stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scos_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [scos_pkg::MEAN_W-1:0]    rsp_mean_overlap,
   input logic        [scos_pkg::COORD_W-1:0]   rsp_coord_num,
   input logic        [scos_pkg::CONTACT_W-1:0] rsp_contact_count,
   input logic        [scos_pkg::SPHERE_W-1:0]  rsp_sphere_count
);
   import scos_pkg::*;

   `SCOS_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)
   `SCOS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mean_overlap) && $stable(rsp_contact_count))
   `SCOS_ASSERT_IMP(a_even_contacts, clock, reset, rsp_valid, (rsp_contact_count[0] == 1'b0) || (rsp_contact_count == CONTACT_MAX))
   `SCOS_ASSERT_IMP(a_no_contact_zero, clock, reset, rsp_valid && (rsp_contact_count == '0), (rsp_mean_overlap == '0) && (rsp_coord_num == '0))
   `SCOS_ASSERT_IMP(a_single_no_pair, clock, reset, rsp_valid && (rsp_sphere_count < 7'd2), rsp_contact_count == '0)

endmodule

bind sphere_contact_overlap_stats scos_checker u_scos_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_mean_overlap  (rsp_chan.mean_overlap),
   .rsp_coord_num     (rsp_chan.coord_num),
   .rsp_contact_count (rsp_chan.contact_count),
   .rsp_sphere_count  (rsp_chan.sphere_count)
);
